// File: sv/rwl_pkg.sv
// shared types and constants of the reader-writer lock manager
package rwl_pkg;

   // fixed field widths
   localparam int HANDLE_BITS = 16;
   localparam int CLIENT_BITS = 4;
   localparam int CMD_BITS = 2;
   localparam int VERDICT_BITS = 2;

   // wait queues
   localparam int QUEUE_DEPTH = 16;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // parameter defaults
   localparam int DEF_NUM_CLIENTS = 16;
   localparam int DEF_HOLD_COUNT_BITS = 8;

   // request commands
   localparam logic [CMD_BITS-1:0] CMD_WR_LOCK = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_WR_UNLOCK = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_RD_LOCK = 2'd2;
   localparam logic [CMD_BITS-1:0] CMD_RD_UNLOCK = 2'd3;

   // response verdicts
   localparam logic [VERDICT_BITS-1:0] VERDICT_PERMIT = 2'd0;
   localparam logic [VERDICT_BITS-1:0] VERDICT_THROW = 2'd1;
   localparam logic [VERDICT_BITS-1:0] VERDICT_REFUSED = 2'd2;

   // one response word
   typedef struct packed {
      logic [HANDLE_BITS-1:0] handle;
      logic [CLIENT_BITS-1:0] dest_client;
      logic [VERDICT_BITS-1:0] verdict;
      logic last;
   } rsp_word_type;

endpackage

// File: sv/rwl_ram.sv
// generic single-port-write, registered-read memory
module rwl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

// File: sv/rwl_rsp_buf.sv
// two-word response buffer between the lock logic and the response channel
module rwl_rsp_buf
   import rwl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push_a,
   input  rsp_word_type word_a,
   input  logic         push_b,
   input  rsp_word_type word_b,
   output logic [1:0]   count,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   rsp_word_type ent_ff [2];
   rsp_word_type ent_in [2];
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   logic [1:0] cnt_pop;
   logic pop;

   assign count = cnt_ff;
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_word = ent_ff[0];
   assign pop = rsp_valid && rsp_ready;

   // shift out on pop, then append new words behind what is left
   always_comb begin
      cnt_pop = cnt_ff - {1'b0, pop};
      ent_in[0] = pop ? ent_ff[1] : ent_ff[0];
      ent_in[1] = ent_ff[1];
      if (push_a) begin
         if (cnt_pop == 2'd0) begin
            ent_in[0] = word_a;
         end else begin
            ent_in[1] = word_a;
         end
      end
      if (push_b) begin
         ent_in[1] = word_b;
      end
      cnt_in = cnt_pop + {1'b0, push_a} + {1'b0, push_b};
   end

   // fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      ent_ff[0] <= ent_in[0];
      ent_ff[1] <= ent_in[1];
   end

endmodule

// File: sv/reader_writer_lock_manager.sv
// top level of the reader-writer lock manager
//
// Arbitrates one lock between NUM_CLIENTS clients. A request word is taken
// only when the lock logic is idle; the hold-count memory and the heads of
// the two wait queues are then read, and the lookup state decides and writes
// back. A write unlock that retries a queued reader goes on to the retry
// state, which does a second read of the
// hold-count memory. Responses (one or two per request, queued requests get
// none until retried) leave through a two-word buffer; the decision cycle
// waits until the responses of the previous request have drained. Per-client
// hold counts are marked empty by reset at once, so no clearing pass is needed.
module reader_writer_lock_manager
   import rwl_pkg::*;
#(
   parameter int NUM_CLIENTS = DEF_NUM_CLIENTS,
   parameter int HOLD_COUNT_BITS = DEF_HOLD_COUNT_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   // configuration
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [HANDLE_BITS-1:0]  csr_lock_handle,
   // requests
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [CMD_BITS-1:0]     req_cmd,
   input  logic [CLIENT_BITS-1:0]  req_client_id,
   // responses
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [HANDLE_BITS-1:0]  rsp_handle,
   output logic [CLIENT_BITS-1:0]  rsp_dest_client,
   output logic [VERDICT_BITS-1:0] rsp_verdict,
   output logic                    rsp_last
);

   localparam int HA = $clog2(NUM_CLIENTS);
   localparam int AW = $clog2(NUM_CLIENTS + 1);
   localparam logic [HOLD_COUNT_BITS-1:0] HOLD_MAX = {HOLD_COUNT_BITS{1'b1}};

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_LOOKUP = 3'b010,
      ST_RETRY  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [HANDLE_BITS-1:0] lock_handle_ff;
   logic writer_valid_ff, writer_valid_in;
   logic [CLIENT_BITS-1:0] writer_client_ff, writer_client_in;
   logic [AW-1:0] active_ff, active_in;
   logic [NUM_CLIENTS-1:0] hold_valid_ff, hold_valid_in;
   logic [QUEUE_PTR_BITS-1:0] wq_head_ff, wq_head_in, rq_head_ff, rq_head_in;
   logic [QUEUE_CNT_BITS-1:0] wq_count_ff, wq_count_in, rq_count_ff, rq_count_in;
   logic [CMD_BITS-1:0] cmd_ff, cmd_in;
   logic [CLIENT_BITS-1:0] client_ff, client_in;
   logic [CLIENT_BITS-1:0] retry_client_ff, retry_client_in;
   logic [HA-1:0] hold_addr_ff, hold_addr_in;

   // memory ports
   logic hold_we, hold_re;
   logic [HA-1:0] hold_waddr, hold_raddr;
   logic [HOLD_COUNT_BITS-1:0] hold_wdata, hold_rdata, hold_val;
   logic wq_we, rq_we, q_re;
   logic [QUEUE_PTR_BITS-1:0] wq_tail, rq_tail, wq_waddr;
   logic [CLIENT_BITS-1:0] wq_wdata, wq_rdata, rq_rdata;

   // decision signals
   logic in_range;
   logic do_wretry, wretry_grant;
   logic push_a, push_b;
   rsp_word_type word_a, word_b, rsp_word;
   logic [1:0] buf_count;
   logic accept;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign accept = req_valid && req_ready;
   assign q_re = accept;
   assign in_range = (32'(client_ff) < NUM_CLIENTS);
   assign wq_tail = wq_head_ff + wq_count_ff[QUEUE_PTR_BITS-1:0];
   assign rq_tail = rq_head_ff + rq_count_ff[QUEUE_PTR_BITS-1:0];
   assign hold_val = hold_valid_ff[hold_addr_ff] ? hold_rdata : '0;

   // hold counts per client
   rwl_ram #(.WIDTH(HOLD_COUNT_BITS), .DEPTH(NUM_CLIENTS)) u_hold_ram (
      .clock (clock),
      .we    (hold_we),
      .waddr (hold_waddr),
      .wdata (hold_wdata),
      .re    (hold_re),
      .raddr (hold_raddr),
      .rdata (hold_rdata)
   );

   // waiting writers
   rwl_ram #(.WIDTH(CLIENT_BITS), .DEPTH(QUEUE_DEPTH)) u_wq_ram (
      .clock (clock),
      .we    (wq_we),
      .waddr (wq_waddr),
      .wdata (wq_wdata),
      .re    (q_re),
      .raddr (wq_head_ff),
      .rdata (wq_rdata)
   );

   // waiting readers
   rwl_ram #(.WIDTH(CLIENT_BITS), .DEPTH(QUEUE_DEPTH)) u_rq_ram (
      .clock (clock),
      .we    (rq_we),
      .waddr (rq_tail),
      .wdata (client_ff),
      .re    (q_re),
      .raddr (rq_head_ff),
      .rdata (rq_rdata)
   );

   // lock decision and write-back
   always_comb begin
      state_in = state_ff;
      writer_valid_in = writer_valid_ff;
      writer_client_in = writer_client_ff;
      active_in = active_ff;
      hold_valid_in = hold_valid_ff;
      wq_head_in = wq_head_ff;
      wq_count_in = wq_count_ff;
      rq_head_in = rq_head_ff;
      rq_count_in = rq_count_ff;
      cmd_in = cmd_ff;
      client_in = client_ff;
      retry_client_in = retry_client_ff;
      hold_addr_in = hold_addr_ff;

      hold_re = 1'b0;
      hold_raddr = HA'(req_client_id);
      hold_we = 1'b0;
      hold_waddr = HA'(client_ff);
      hold_wdata = hold_val + HOLD_COUNT_BITS'(1);
      wq_we = 1'b0;
      wq_waddr = wq_tail;
      wq_wdata = client_ff;
      rq_we = 1'b0;

      do_wretry = 1'b0;
      wretry_grant = 1'b0;
      push_a = 1'b0;
      push_b = 1'b0;
      word_a = '{handle: lock_handle_ff, dest_client: client_ff,
                 verdict: VERDICT_PERMIT, last: 1'b1};
      word_b = '{handle: lock_handle_ff, dest_client: wq_rdata,
                 verdict: VERDICT_PERMIT, last: 1'b1};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in = req_cmd;
               client_in = req_client_id;
               hold_re = 1'b1;
               hold_addr_in = HA'(req_client_id);
               state_in = ST_LOOKUP;
            end
         end

         ST_LOOKUP: begin
            if (buf_count == 2'd0) begin
               push_a = 1'b1;
               state_in = ST_IDLE;
               if (!in_range) begin
                  word_a.verdict = VERDICT_REFUSED;
               end else begin
                  case (cmd_ff)
                     CMD_WR_LOCK: begin
                        if (!writer_valid_ff && active_ff == '0) begin
                           writer_valid_in = 1'b1;
                           writer_client_in = client_ff;
                        end else if (wq_count_ff < QUEUE_CNT_BITS'(QUEUE_DEPTH)) begin
                           wq_we = 1'b1;
                           wq_count_in = wq_count_ff + QUEUE_CNT_BITS'(1);
                           push_a = 1'b0;
                        end else begin
                           word_a.verdict = VERDICT_REFUSED;
                        end
                     end

                     CMD_WR_UNLOCK: begin
                        if (!writer_valid_ff || writer_client_ff != client_ff) begin
                           word_a.verdict = VERDICT_THROW;
                        end else begin
                           writer_valid_in = 1'b0;
                           if (wq_count_ff != '0) begin
                              do_wretry = 1'b1;
                              wretry_grant = (active_ff == '0);
                           end else if (rq_count_ff != '0) begin
                              // reader retry needs its own hold count
                              rq_head_in = rq_head_ff + QUEUE_PTR_BITS'(1);
                              rq_count_in = rq_count_ff - QUEUE_CNT_BITS'(1);
                              retry_client_in = rq_rdata;
                              hold_re = 1'b1;
                              hold_raddr = HA'(rq_rdata);
                              hold_addr_in = HA'(rq_rdata);
                              word_a.last = 1'b0;
                              state_in = ST_RETRY;
                           end
                        end
                     end

                     CMD_RD_LOCK: begin
                        if (!writer_valid_ff || writer_client_ff == client_ff) begin
                           if (hold_val == HOLD_MAX) begin
                              word_a.verdict = VERDICT_REFUSED;
                           end else begin
                              if (hold_val == '0) begin
                                 active_in = active_ff + AW'(1);
                              end
                              hold_we = 1'b1;
                              hold_valid_in[hold_addr_ff] = 1'b1;
                           end
                        end else if (rq_count_ff < QUEUE_CNT_BITS'(QUEUE_DEPTH)) begin
                           rq_we = 1'b1;
                           rq_count_in = rq_count_ff + QUEUE_CNT_BITS'(1);
                           push_a = 1'b0;
                        end else begin
                           word_a.verdict = VERDICT_REFUSED;
                        end
                     end

                     CMD_RD_UNLOCK: begin
                        if (hold_val == '0) begin
                           word_a.verdict = VERDICT_THROW;
                        end else begin
                           hold_we = 1'b1;
                           hold_wdata = hold_val - HOLD_COUNT_BITS'(1);
                           if (hold_val == HOLD_COUNT_BITS'(1)) begin
                              active_in = active_ff - AW'(1);
                              if (active_ff == AW'(1) && wq_count_ff != '0) begin
                                 do_wretry = 1'b1;
                                 wretry_grant = !writer_valid_ff;
                              end
                           end
                        end
                     end

                     default: begin
                        push_a = 1'b0;
                     end
                  endcase
               end

               // retry of the writer at the queue head
               if (do_wretry) begin
                  wq_head_in = wq_head_ff + QUEUE_PTR_BITS'(1);
                  if (wretry_grant) begin
                     writer_valid_in = 1'b1;
                     writer_client_in = wq_rdata;
                     wq_count_in = wq_count_ff - QUEUE_CNT_BITS'(1);
                     push_b = 1'b1;
                     word_a.last = 1'b0;
                  end else begin
                     // back to the tail, count unchanged
                     wq_we = 1'b1;
                     wq_wdata = wq_rdata;
                  end
               end
            end
         end

         ST_RETRY: begin
            // queued reader after a write unlock: no writer is left
            push_a = 1'b1;
            state_in = ST_IDLE;
            word_a.dest_client = retry_client_ff;
            hold_waddr = hold_addr_ff;
            if (hold_val == HOLD_MAX) begin
               word_a.verdict = VERDICT_REFUSED;
            end else begin
               if (hold_val == '0) begin
                  active_in = active_ff + AW'(1);
               end
               hold_we = 1'b1;
               hold_valid_in[hold_addr_ff] = 1'b1;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lock_handle_ff <= '0;
         writer_valid_ff <= 1'b0;
         writer_client_ff <= '0;
         active_ff <= '0;
         hold_valid_ff <= '0;
         wq_head_ff <= '0;
         wq_count_ff <= '0;
         rq_head_ff <= '0;
         rq_count_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            lock_handle_ff <= csr_lock_handle;
         end
         writer_valid_ff <= writer_valid_in;
         writer_client_ff <= writer_client_in;
         active_ff <= active_in;
         hold_valid_ff <= hold_valid_in;
         wq_head_ff <= wq_head_in;
         wq_count_ff <= wq_count_in;
         rq_head_ff <= rq_head_in;
         rq_count_ff <= rq_count_in;
      end
   end

   // request payload
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      client_ff <= client_in;
      retry_client_ff <= retry_client_in;
      hold_addr_ff <= hold_addr_in;
   end

   // response buffer
   rwl_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push_a    (push_a),
      .word_a    (word_a),
      .push_b    (push_b),
      .word_b    (word_b),
      .count     (buf_count),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   assign rsp_handle = rsp_word.handle;
   assign rsp_dest_client = rsp_word.dest_client;
   assign rsp_verdict = rsp_word.verdict;
   assign rsp_last = rsp_word.last;

endmodule

// File: test/tb_reader_writer_lock_manager.sv
// self-checking testbench of the reader-writer lock manager
module tb_reader_writer_lock_manager
   import rwl_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_CLIENTS = DEF_NUM_CLIENTS;
   localparam int HOLD_BITS = DEF_HOLD_COUNT_BITS;
   localparam int HOLD_MAX = (1 << HOLD_BITS) - 1;
   // longest quiet stretch is the receiver hold-off plus one drain pause
   localparam int RSP_HOLD_OFF_CYCLES = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SCRIPT_LEN = 22;

   typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_PERIODIC} sink_mode_type;

   // one directed request, with its responses typed in where they are obvious
   typedef struct packed {
      logic [CMD_BITS-1:0]     cmd;
      logic [CLIENT_BITS-1:0]  client;
      logic                    typed;
      logic [1:0]              n;
      logic [VERDICT_BITS-1:0] v0;
      logic [VERDICT_BITS-1:0] v1;
   } script_row_type;

   logic                    clock;
   logic                    reset;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [HANDLE_BITS-1:0]  csr_lock_handle;
   logic                    req_valid;
   logic                    req_ready;
   logic [CMD_BITS-1:0]     req_cmd;
   logic [CLIENT_BITS-1:0]  req_client_id;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic [HANDLE_BITS-1:0]  rsp_handle;
   logic [CLIENT_BITS-1:0]  rsp_dest_client;
   logic [VERDICT_BITS-1:0] rsp_verdict;
   logic                    rsp_last;

   // lock state as the block should hold it
   logic [HANDLE_BITS-1:0]  handle_cfg;
   logic                    wr_held;
   logic [CLIENT_BITS-1:0]  wr_owner;
   logic [HOLD_BITS-1:0]    read_count [N_CLIENTS];
   int unsigned             n_readers;
   logic [CLIENT_BITS-1:0]  wr_waiting [$];
   logic [CLIENT_BITS-1:0]  rd_waiting [$];
   rsp_word_type            step_rsps [$];   // responses of the latest request
   rsp_word_type            lock_rsp_q [$];  // responses still due from the block

   int errors = 0;
   int burst_left = 0;
   int hold_off_requests = 0;
   int hold_off_served = 0;
   int quiet_cycles = 0;

   script_row_type script [SCRIPT_LEN] = '{
      '{CMD_WR_UNLOCK, 4'd0,  1'b1, 2'd1, VERDICT_THROW,  VERDICT_PERMIT},
      '{CMD_RD_UNLOCK, 4'd15, 1'b1, 2'd1, VERDICT_THROW,  VERDICT_PERMIT},
      '{CMD_WR_LOCK,   4'd0,  1'b1, 2'd1, VERDICT_PERMIT, VERDICT_PERMIT},
      '{CMD_WR_LOCK,   4'd0,  1'b1, 2'd0, VERDICT_PERMIT, VERDICT_PERMIT},
      '{CMD_RD_LOCK,   4'd0,  1'b1, 2'd1, VERDICT_PERMIT, VERDICT_PERMIT},
      '{CMD_RD_LOCK,   4'd15, 1'b1, 2'd0, VERDICT_PERMIT, VERDICT_PERMIT},
      '{CMD_WR_UNLOCK, 4'd15, 1'b1, 2'd1, VERDICT_THROW,  VERDICT_PERMIT},
      '{CMD_RD_UNLOCK, 4'd15, 1'b1, 2'd1, VERDICT_THROW,  VERDICT_PERMIT},
      '{CMD_WR_UNLOCK, 4'd0,  1'b0, 2'd0, VERDICT_PERMIT, VERDICT_PERMIT},
      '{CMD_WR_LOCK,   4'd10, 1'b0, 2'd0, VERDICT_PERMIT, VERDICT_PERMIT},
      '{CMD_RD_LOCK,   4'd5,  1'b0, 2'd0, VERDICT_PERMIT, VERDICT_PERMIT},
      '{CMD_RD_UNLOCK, 4'd0,  1'b0, 2'd0, VERDICT_PERMIT, VERDICT_PERMIT},
      '{CMD_RD_UNLOCK, 4'd5,  1'b0, 2'd0, VERDICT_PERMIT, VERDICT_PERMIT},
      '{CMD_WR_UNLOCK, 4'd0,  1'b0, 2'd0, VERDICT_PERMIT, VERDICT_PERMIT},
      '{CMD_RD_LOCK,   4'd10, 1'b0, 2'd0, VERDICT_PERMIT, VERDICT_PERMIT},
      '{CMD_WR_UNLOCK, 4'd10, 1'b0, 2'd0, VERDICT_PERMIT, VERDICT_PERMIT},
      '{CMD_RD_UNLOCK, 4'd10, 1'b0, 2'd0, VERDICT_PERMIT, VERDICT_PERMIT},
      '{CMD_RD_UNLOCK, 4'd15, 1'b0, 2'd0, VERDICT_PERMIT, VERDICT_PERMIT},
      '{CMD_WR_LOCK,   4'd15, 1'b0, 2'd0, VERDICT_PERMIT, VERDICT_PERMIT},
      '{CMD_RD_LOCK,   4'd6,  1'b0, 2'd0, VERDICT_PERMIT, VERDICT_PERMIT},
      '{CMD_WR_UNLOCK, 4'd15, 1'b0, 2'd0, VERDICT_PERMIT, VERDICT_PERMIT},
      '{CMD_RD_UNLOCK, 4'd6,  1'b0, 2'd0, VERDICT_PERMIT, VERDICT_PERMIT}
   };

   reader_writer_lock_manager #(
      .NUM_CLIENTS     (N_CLIENTS),
      .HOLD_COUNT_BITS (HOLD_BITS)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_lock_handle (csr_lock_handle),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_client_id   (req_client_id),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_handle      (rsp_handle),
      .rsp_dest_client (rsp_dest_client),
      .rsp_verdict     (rsp_verdict),
      .rsp_last        (rsp_last)
   );

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // queue one response of the current request
   function automatic void add_rsp(input logic [CLIENT_BITS-1:0] dest,
                                   input logic [VERDICT_BITS-1:0] verdict);
      rsp_word_type w;
      w.handle = handle_cfg;
      w.dest_client = dest;
      w.verdict = verdict;
      w.last = 1'b0;
      step_rsps.push_back(w);
   endfunction

   // write lock: grant when free, else wait, else refuse
   function automatic void try_grant_write(input logic [CLIENT_BITS-1:0] c);
      if (!wr_held && n_readers == 0) begin
         wr_held = 1'b1;
         wr_owner = c;
         add_rsp(c, VERDICT_PERMIT);
      end else if (wr_waiting.size() < QUEUE_DEPTH) begin
         wr_waiting.push_back(c);
      end else begin
         add_rsp(c, VERDICT_REFUSED);
      end
   endfunction

   // read lock: grant with no writer or to the writer itself, else wait, else refuse
   function automatic void try_grant_read(input logic [CLIENT_BITS-1:0] c);
      if (!wr_held || wr_owner == c) begin
         if (read_count[c] == HOLD_MAX[HOLD_BITS-1:0]) begin
            add_rsp(c, VERDICT_REFUSED);
         end else begin
            if (read_count[c] == '0) n_readers++;
            read_count[c]++;
            add_rsp(c, VERDICT_PERMIT);
         end
      end else if (rd_waiting.size() < QUEUE_DEPTH) begin
         rd_waiting.push_back(c);
      end else begin
         add_rsp(c, VERDICT_REFUSED);
      end
   endfunction

   // work out the responses of one accepted request word
   function automatic void predict_request(input logic [CMD_BITS-1:0] cmd,
                                           input logic [CLIENT_BITS-1:0] c);
      rsp_word_type w;
      step_rsps.delete();
      if (int'(c) >= N_CLIENTS) begin
         add_rsp(c, VERDICT_REFUSED);
      end else begin
         case (cmd)
            CMD_WR_LOCK: try_grant_write(c);
            CMD_WR_UNLOCK: begin
               if (!wr_held || wr_owner != c) begin
                  add_rsp(c, VERDICT_THROW);
               end else begin
                  wr_held = 1'b0;
                  add_rsp(c, VERDICT_PERMIT);
                  if (wr_waiting.size() != 0) try_grant_write(wr_waiting.pop_front());
                  else if (rd_waiting.size() != 0) try_grant_read(rd_waiting.pop_front());
               end
            end
            CMD_RD_LOCK: try_grant_read(c);
            CMD_RD_UNLOCK: begin
               if (read_count[c] == '0) begin
                  add_rsp(c, VERDICT_THROW);
               end else begin
                  read_count[c]--;
                  add_rsp(c, VERDICT_PERMIT);
                  if (read_count[c] == '0) begin
                     n_readers--;
                     // last reader gone: a waiting writer gets its turn
                     if (n_readers == 0 && wr_waiting.size() != 0)
                        try_grant_write(wr_waiting.pop_front());
                  end
               end
            end
            default: ;
         endcase
      end
      if (step_rsps.size() != 0) begin
         w = step_rsps.pop_back();
         w.last = 1'b1;
         step_rsps.push_back(w);
      end
      foreach (step_rsps[i]) lock_rsp_q.push_back(step_rsps[i]);
   endfunction

   // offer one request word and hold it until taken; bursts with gaps
   task automatic offer_request(input logic [CMD_BITS-1:0] cmd,
                                input logic [CLIENT_BITS-1:0] c);
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_client_id <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_request(cmd, c);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(9) == 0) ? 60 : $urandom_range(1, 20);
      end
   endtask

   // stop sending and wait for every due response, then a margin
   task automatic settle_idle(input int margin);
      req_valid <= 1'b0;
      while (lock_rsp_q.size() != 0) @(posedge clock);
      repeat (margin) @(posedge clock);
   endtask

   task automatic write_lock_handle(input logic [HANDLE_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_lock_handle <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      handle_cfg = value;
   endtask

   // unwind the lock until nobody holds or waits
   task automatic release_all_locks();
      int guard;
      logic [CLIENT_BITS-1:0] holder;
      guard = 0;
      holder = '0;
      while (guard < 2000 &&
             (wr_held || n_readers != 0 || wr_waiting.size() != 0 || rd_waiting.size() != 0)) begin
         guard++;
         if (wr_held) begin
            offer_request(CMD_WR_UNLOCK, wr_owner);
         end else if (n_readers != 0) begin
            for (int k = 0; k < N_CLIENTS; k++)
               if (read_count[k] != '0) holder = k[CLIENT_BITS-1:0];
            offer_request(CMD_RD_UNLOCK, holder);
         end else begin
            // free lock with stragglers queued: take it so unlocks retry them
            offer_request(CMD_WR_LOCK, CLIENT_BITS'($urandom_range(N_CLIENTS - 1)));
         end
      end
   endtask

   // both wait queues past full
   task automatic fill_wait_queues();
      logic [CLIENT_BITS-1:0] owner;
      release_all_locks();
      owner = CLIENT_BITS'($urandom_range(N_CLIENTS - 1));
      offer_request(CMD_WR_LOCK, owner);
      repeat (QUEUE_DEPTH + 1)
         offer_request(CMD_WR_LOCK, CLIENT_BITS'($urandom_range(N_CLIENTS - 1)));
      repeat (QUEUE_DEPTH + 1)
         offer_request(CMD_RD_LOCK,
                       CLIENT_BITS'(owner + $urandom_range(1, N_CLIENTS - 1)));
   endtask

   // hold count at its limit, both directly and for a reader retried from its queue
   task automatic saturate_read_holds();
      logic [CLIENT_BITS-1:0] sat_client;
      logic [CLIENT_BITS-1:0] other;
      release_all_locks();
      sat_client = CLIENT_BITS'($urandom_range(N_CLIENTS - 1));
      other = CLIENT_BITS'(sat_client + $urandom_range(1, N_CLIENTS - 1));
      offer_request(CMD_WR_LOCK, other);
      offer_request(CMD_RD_LOCK, sat_client);
      offer_request(CMD_WR_LOCK, sat_client);
      offer_request(CMD_WR_UNLOCK, other);
      repeat (HOLD_MAX) offer_request(CMD_RD_LOCK, sat_client);
      offer_request(CMD_RD_LOCK, sat_client);
      offer_request(CMD_WR_UNLOCK, sat_client);
      release_all_locks();
   endtask

   // mostly sensible requests from a small group of clients, some noise
   task automatic random_requests(input int count);
      logic [CMD_BITS-1:0] cmd;
      logic [CLIENT_BITS-1:0] c;
      int pool_lo;
      int start;
      repeat (count) begin
         cmd = CMD_BITS'($urandom_range(3));
         pool_lo = $urandom_range(N_CLIENTS - 4);
         c = ($urandom_range(4) == 0) ? CLIENT_BITS'($urandom_range(N_CLIENTS - 1))
                                      : CLIENT_BITS'(pool_lo + $urandom_range(3));
         if ($urandom_range(9) != 0) begin
            case (cmd)
               CMD_WR_UNLOCK: begin
                  if (wr_held && $urandom_range(9) != 0) c = wr_owner;
               end
               CMD_RD_UNLOCK: begin
                  if (n_readers != 0 && $urandom_range(9) != 0) begin
                     start = $urandom_range(N_CLIENTS - 1);
                     for (int k = N_CLIENTS - 1; k >= 0; k--)
                        if (read_count[CLIENT_BITS'((start + k) % N_CLIENTS)] != '0)
                           c = CLIENT_BITS'((start + k) % N_CLIENTS);
                  end
               end
               CMD_RD_LOCK: begin
                  if (wr_held && $urandom_range(3) == 0) c = wr_owner;
               end
               default: ;
            endcase
         end
         offer_request(cmd, c);
      end
   endtask

   // stimulus and end of run
   initial begin : stimulus
      logic [HANDLE_BITS-1:0] handles [5];
      script_row_type row;
      logic bad;
      req_valid <= 1'b0;
      req_cmd <= '0;
      req_client_id <= '0;
      csr_valid <= 1'b0;
      csr_lock_handle <= '0;
      reset <= 1'b1;
      handle_cfg = '0;
      wr_held = 1'b0;
      wr_owner = '0;
      foreach (read_count[i]) read_count[i] = '0;
      n_readers = 0;
      handles[0] = 16'hFFFF;
      handles[1] = 16'h0000;
      handles[2] = HANDLE_BITS'($urandom);
      handles[3] = 16'h8001;
      handles[4] = HANDLE_BITS'($urandom);
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed part, handle still at its reset value
      for (int i = 0; i < SCRIPT_LEN; i++) begin
         row = script[i];
         offer_request(row.cmd, row.client);
         if (row.typed) begin
            bad = (step_rsps.size() != int'(row.n));
            if (!bad && row.n > 0) bad = (step_rsps[0].verdict != row.v0);
            if (!bad && row.n > 1) bad = (step_rsps[1].verdict != row.v1);
            if (bad) begin
               $display("%0t: directed row %0d: expected %0d words (%0d %0d), predicted %0d",
                        $time, i, row.n, row.v0, row.v1, step_rsps.size());
               errors++;
            end
         end
      end

      // phases, each with its own lock handle
      for (int p = 0; p < 5; p++) begin
         settle_idle(10);
         write_lock_handle(handles[p]);
         case (p)
            0: fill_wait_queues();
            1: hold_off_requests++;
            2: saturate_read_holds();
            3: fill_wait_queues();
            default: ;
         endcase
         random_requests(p == 1 ? 120 : 80);
      end

      settle_idle(30);
      if (errors == 0 && lock_rsp_q.size() == 0) begin
         $display("reader_writer_lock_manager verification clean");
      end else begin
         $display("reader_writer_lock_manager verification failed");
      end
      $finish;
   end

   // receiver: changing stall patterns, one long hold-off on request
   initial begin : response_sink
      sink_mode_type mode;
      int left;
      int tick;
      rsp_ready <= 1'b0;
      mode = SINK_OPEN;
      left = 0;
      tick = 0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_off_requests != hold_off_served) begin
            hold_off_served++;
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            if (left == 0) begin
               mode = sink_mode_type'($urandom_range(3));
               left = $urandom_range(16, 96);
            end
            left--;
            case (mode)
               SINK_OPEN:   rsp_ready <= 1'b1;
               SINK_COIN:   rsp_ready <= ($urandom_range(1) == 1);
               SINK_SPARSE: rsp_ready <= ($urandom_range(4) == 0);
               default:     rsp_ready <= (tick % 3) != 0;
            endcase
         end
      end
   end

   // compare each response word with the oldest one due
   always @(posedge clock) begin : rsp_check
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (lock_rsp_q.size() == 0) begin
            $display("%0t: unexpected response word: dest %0d verdict %0d last %0d",
                     $time, rsp_dest_client, rsp_verdict, rsp_last);
            errors++;
         end else begin
            want = lock_rsp_q.pop_front();
            if (rsp_handle !== want.handle) begin
               $display("%0t: handle expected %h actual %h", $time, want.handle, rsp_handle);
               errors++;
            end
            if (rsp_dest_client !== want.dest_client) begin
               $display("%0t: dest_client expected %0d actual %0d",
                        $time, want.dest_client, rsp_dest_client);
               errors++;
            end
            if (rsp_verdict !== want.verdict) begin
               $display("%0t: verdict expected %0d actual %0d", $time, want.verdict, rsp_verdict);
               errors++;
            end
            if (rsp_last !== want.last) begin
               $display("%0t: last expected %0d actual %0d", $time, want.last, rsp_last);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles with no word moving on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles, %0d words still due",
                  $time, quiet_cycles, lock_rsp_q.size());
         $display("reader_writer_lock_manager verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

// File: reader_writer_lock_manager.f
sv/rwl_pkg.sv
sv/rwl_ram.sv
sv/rwl_rsp_buf.sv
sv/reader_writer_lock_manager.sv
test/tb_reader_writer_lock_manager.sv
